FILE: hw/rtl/line_follow_pd_controller_core_defines.svh
// Assertion macros for the line follower PD controller core
`ifndef LINE_FOLLOW_PD_CONTROLLER_CORE_DEFINES_SVH
`define LINE_FOLLOW_PD_CONTROLLER_CORE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define LFPD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define LFPD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/lfpd_pkg.sv
// Shared types, constants and helpers for the line follower PD controller
package lfpd_pkg;

    localparam int LEVEL_W = 10;
    localparam int DIST_W  = 16;
    localparam int GAIN_W  = 8;
    localparam int DRIVE_W = 14;
    localparam int ERR_W   = 5;
    localparam int PHASE_W = 3;
    localparam int RUN_W   = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 40;

    localparam int DIV_Q_W   = 12;
    localparam int DIV_D_W   = RUN_W + 1;
    localparam int DIV_CNT_W = $clog2(DIV_Q_W);

    localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_THR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_SPEED = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GATE_DIST  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BEACON_THR = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_DIST  = 3'd6;

    localparam logic [LEVEL_W-1:0] RST_SENSOR_THR = 10'd200;
    localparam logic [GAIN_W-1:0]  RST_PROP_GAIN  = 8'd20;
    localparam logic [GAIN_W-1:0]  RST_DERIV_GAIN = 8'd10;
    localparam logic [LEVEL_W-1:0] RST_BASE_SPEED = 10'd120;
    localparam logic [DIST_W-1:0]  RST_GATE_DIST  = 16'd1000;
    localparam logic [LEVEL_W-1:0] RST_BEACON_THR = 10'd500;
    localparam logic [DIST_W-1:0]  RST_SLOW_DIST  = 16'd2000;

    localparam logic [LEVEL_W-1:0] SLOW_THRESHOLD = 10'd150;
    localparam logic [LEVEL_W-1:0] SLOW_SPEED     = 10'd90;
    localparam logic [GAIN_W-1:0]  SLOW_PROP      = 8'd25;
    localparam logic [GAIN_W-1:0]  SLOW_DERIV     = 8'd12;
    localparam logic [DIST_W-1:0]  CROSS_MIN_MS   = 16'd5000;

    localparam logic signed [ERR_W-1:0] ERR_ALL_ON   = 5'sd10;
    localparam logic signed [ERR_W-1:0] ERR_CENTRE   = 5'sd0;
    localparam logic signed [ERR_W-1:0] ERR_LEFT     = -5'sd1;
    localparam logic signed [ERR_W-1:0] ERR_RIGHT    = 5'sd1;
    localparam logic signed [ERR_W-1:0] ERR_LOST_POS = 5'sd2;
    localparam logic signed [ERR_W-1:0] ERR_LOST_NEG = -5'sd2;

    localparam logic [PHASE_W-1:0] PH_FOLLOW    = 3'd0;
    localparam logic [PHASE_W-1:0] PH_WAIT_RISE = 3'd1;
    localparam logic [PHASE_W-1:0] PH_WAIT_FALL = 3'd2;
    localparam logic [PHASE_W-1:0] PH_TURN      = 3'd3;
    localparam logic [PHASE_W-1:0] PH_DONE      = 3'd4;

    typedef struct packed {
        logic [LEVEL_W-1:0] sensor_threshold;
        logic [GAIN_W-1:0]  prop_gain;
        logic [GAIN_W-1:0]  deriv_gain;
        logic [LEVEL_W-1:0] base_speed;
        logic [DIST_W-1:0]  gate_distance;
        logic [LEVEL_W-1:0] beacon_threshold;
        logic [DIST_W-1:0]  slow_distance;
    } t_cfg;

    function automatic logic [PHASE_W-1:0] beacon_next(
        input logic [PHASE_W-1:0] ph,
        input logic [LEVEL_W-1:0] beacon,
        input logic [LEVEL_W-1:0] thr
    );
        logic [PHASE_W-1:0] p;
        p = ph;
        if (p == PH_WAIT_RISE && beacon >= thr) begin
            p = PH_WAIT_FALL;
        end
        if (p == PH_WAIT_FALL && beacon <= thr) begin
            p = PH_FOLLOW;
        end
        return p;
    endfunction

endpackage

FILE: hw/rtl/lfpd_cfg.sv
// Configuration register file for the line follower PD controller
module lfpd_cfg
    import lfpd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sensor_threshold <= RST_SENSOR_THR;
            r_cfg.prop_gain        <= RST_PROP_GAIN;
            r_cfg.deriv_gain       <= RST_DERIV_GAIN;
            r_cfg.base_speed       <= RST_BASE_SPEED;
            r_cfg.gate_distance    <= RST_GATE_DIST;
            r_cfg.beacon_threshold <= RST_BEACON_THR;
            r_cfg.slow_distance    <= RST_SLOW_DIST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_SENSOR_THR: r_cfg.sensor_threshold <= i_cfg_wdata[LEVEL_W-1:0];
                CFG_PROP_GAIN:  r_cfg.prop_gain        <= i_cfg_wdata[GAIN_W-1:0];
                CFG_DERIV_GAIN: r_cfg.deriv_gain       <= i_cfg_wdata[GAIN_W-1:0];
                CFG_BASE_SPEED: r_cfg.base_speed       <= i_cfg_wdata[LEVEL_W-1:0];
                CFG_GATE_DIST:  r_cfg.gate_distance    <= i_cfg_wdata[DIST_W-1:0];
                CFG_BEACON_THR: r_cfg.beacon_threshold <= i_cfg_wdata[LEVEL_W-1:0];
                CFG_SLOW_DIST:  r_cfg.slow_distance    <= i_cfg_wdata[DIST_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: hw/rtl/lfpd_div.sv
// Bit-serial restoring divider for the derivative term
module lfpd_div
    import lfpd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [DIV_Q_W-1:0] i_dividend,
    input  logic [DIV_D_W-1:0] i_divisor,
    output logic               o_done,
    output logic [DIV_Q_W-1:0] o_quotient
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_D_W-1:0]   r_rem;
    logic [DIV_D_W-1:0]   r_den;
    logic [DIV_Q_W-1:0]   r_quo;

    logic [DIV_D_W:0]     w_trial;
    logic [DIV_D_W:0]     w_diff;
    logic                 w_fit;

    // shift in the next dividend bit and try one subtract
    assign w_trial = {r_rem, r_quo[DIV_Q_W-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_fit   = w_trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_Q_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_fit ? w_diff[DIV_D_W-1:0] : w_trial[DIV_D_W-1:0];
            r_quo <= {r_quo[DIV_Q_W-2:0], w_fit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

FILE: hw/rtl/line_follow_pd_controller_core.sv
// Top level of the line follower PD controller core
//
// channel   | dir | handshake                        | payload
// s_axis    | in  | i_s_axis_tvalid/o_s_axis_tready  | one sensor sample
// m_axis    | out | o_m_axis_tvalid/i_m_axis_tready  | drives, error, phase, cross flag
// cfg       | in  | i_cfg_wr_en                      | i_cfg_index, i_cfg_wdata
//
// A sample is accepted, evaluated and then finished, with the serial divider in between
// when the derivative needs it (12 steps, one quotient bit per cycle).
// The next sample is taken while a finished result waits in the output register.
// Reset restores register defaults and clears all controller state.
// A stalled output holds the core in its final step until the register frees.
`include "line_follow_pd_controller_core_defines.svh"

module line_follow_pd_controller_core
    import lfpd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // left_level, centre_left_level, centre_right_level, right_level,
    // left_wheel_distance, right_wheel_distance, beacon_level, elapsed_ms
    input  logic [S_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // left_drive, right_drive, line_error, phase_now, cross_found
    output logic [M_TDATA_W-1:0]  o_m_axis_tdata,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EVAL = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_FIN  = 4'b1000
    } t_state;

    t_cfg   w_cfg;
    t_state r_state;

    // sample registers
    logic [LEVEL_W-1:0] r_lv, r_clv, r_crv, r_rv, r_beacon;
    logic [DIST_W-1:0]  r_ld, r_rd, r_ms;

    // controller state
    logic signed [ERR_W-1:0] r_prior, r_older;
    logic [RUN_W-1:0]        r_run_before, r_run_now;
    logic                    r_gate_done, r_slow;
    logic [PHASE_W-1:0]      r_phase;

    // work registers
    logic signed [DRIVE_W-1:0] r_left_base, r_right_base;
    logic signed [ERR_W-1:0]   r_err;
    logic                      r_neg, r_use_div;

    logic                 r_out_valid;
    logic [M_TDATA_W-1:0] r_out_data;

    logic w_s_accept;
    logic w_out_free;
    logic w_div_done;
    logic [DIV_Q_W-1:0] w_quo;

    logic [DIST_W:0]           w_sum;
    logic [DIST_W-1:0]         w_avg;
    logic                      w_is_follow;
    logic                      w_slow_nx;
    logic [LEVEL_W-1:0]        w_thr, w_spd;
    logic [GAIN_W-1:0]         w_pg, w_dg;
    logic                      w_l, w_cl, w_cr, w_r;
    logic signed [ERR_W-1:0]   w_e;
    logic                      w_changed;
    logic signed [ERR_W-1:0]   w_older_pd;
    logic [RUN_W-1:0]          w_rb_pd, w_rn_pd;
    logic [DIV_D_W-1:0]        w_den;
    logic signed [ERR_W:0]     w_diff;
    logic [ERR_W:0]            w_diff_abs;
    logic [DIV_Q_W-1:0]        w_num_mag;
    logic signed [DRIVE_W-1:0] w_pe, w_spd_s;

    logic signed [ERR_W-1:0]   w_prior_nx, w_older_nx, w_err_nx;
    logic [RUN_W-1:0]          w_rb_nx, w_rn_nx;
    logic                      w_gate_nx, w_use_div_nx;
    logic [PHASE_W-1:0]        w_phase_nx;
    logic signed [DRIVE_W-1:0] w_left_nx, w_right_nx;

    logic signed [DRIVE_W-1:0] w_q_s, w_deriv, w_left_fin, w_right_fin;

    lfpd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    lfpd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == ST_EVAL && w_use_div_nx),
        .i_dividend (w_num_mag),
        .i_divisor  (w_den),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_s_accept      = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free      = !r_out_valid || i_m_axis_tready;

    // sample evaluation
    assign w_sum       = {1'b0, r_ld} + {1'b0, r_rd};
    assign w_avg       = w_sum[DIST_W:1];
    assign w_is_follow = (r_phase == PH_FOLLOW);
    assign w_slow_nx   = r_slow || (w_is_follow && w_avg > w_cfg.slow_distance);
    assign w_thr       = w_slow_nx ? SLOW_THRESHOLD : w_cfg.sensor_threshold;
    assign w_spd       = w_slow_nx ? SLOW_SPEED     : w_cfg.base_speed;
    assign w_pg        = w_slow_nx ? SLOW_PROP      : w_cfg.prop_gain;
    assign w_dg        = w_slow_nx ? SLOW_DERIV     : w_cfg.deriv_gain;

    assign w_l  = r_lv  > w_thr;
    assign w_cl = r_clv > w_thr;
    assign w_cr = r_crv > w_thr;
    assign w_r  = r_rv  > w_thr;

    always_comb begin
        if (w_l && w_cl && w_cr && w_r) begin
            w_e = ERR_ALL_ON;
        end else if (w_cl && w_cr) begin
            w_e = ERR_CENTRE;
        end else if (w_cl) begin
            w_e = ERR_LEFT;
        end else if (w_cr) begin
            w_e = ERR_RIGHT;
        end else if (r_prior > 0) begin
            w_e = ERR_LOST_POS;
        end else begin
            w_e = ERR_LOST_NEG;
        end
    end

    assign w_changed  = (w_e != r_prior);
    assign w_older_pd = w_changed ? r_prior : r_older;
    assign w_rb_pd    = w_changed ? r_run_now : r_run_before;
    assign w_rn_pd    = w_changed ? RUN_W'(1) : r_run_now;
    assign w_den      = {1'b0, w_rb_pd} + {1'b0, w_rn_pd};

    assign w_diff     = {w_e[ERR_W-1], w_e} - {w_older_pd[ERR_W-1], w_older_pd};
    assign w_diff_abs = w_diff[ERR_W] ? (~w_diff + 1'b1) : w_diff;
    assign w_num_mag  = DIV_Q_W'(w_dg * w_diff_abs[3:0]);

    assign w_pe    = $signed({6'b0, w_pg}) * $signed({{(DRIVE_W-ERR_W){w_e[ERR_W-1]}}, w_e});
    assign w_spd_s = $signed({4'b0, w_spd});

    always_comb begin
        w_prior_nx   = r_prior;
        w_older_nx   = r_older;
        w_rb_nx      = r_run_before;
        w_rn_nx      = r_run_now;
        w_gate_nx    = r_gate_done;
        w_phase_nx   = r_phase;
        w_left_nx    = '0;
        w_right_nx   = '0;
        w_err_nx     = ERR_CENTRE;
        w_use_div_nx = 1'b0;
        unique case (r_phase) inside
            PH_FOLLOW: begin
                if (!r_gate_done && w_avg > w_cfg.gate_distance) begin
                    w_gate_nx  = 1'b1;
                    w_phase_nx = beacon_next(PH_WAIT_RISE, r_beacon, w_cfg.beacon_threshold);
                end else begin
                    w_err_nx = w_e;
                    if (w_e == ERR_ALL_ON && r_ms > CROSS_MIN_MS) begin
                        w_phase_nx = PH_TURN;
                        w_left_nx  = -w_spd_s;
                        w_right_nx = -w_spd_s;
                    end else begin
                        w_older_nx   = w_older_pd;
                        w_rb_nx      = w_rb_pd;
                        w_rn_nx      = (w_rn_pd == '1) ? w_rn_pd : w_rn_pd + 1'b1;
                        w_prior_nx   = w_e;
                        w_left_nx    = w_pe - w_spd_s;
                        w_right_nx   = w_pe + w_spd_s;
                        w_use_div_nx = (w_den != '0);
                    end
                end
            end
            PH_WAIT_RISE, PH_WAIT_FALL: begin
                w_phase_nx = beacon_next(r_phase, r_beacon, w_cfg.beacon_threshold);
            end
            PH_TURN: begin
                if (r_clv < w_thr) begin
                    w_left_nx  = -w_spd_s;
                    w_right_nx = -w_spd_s;
                end else begin
                    w_phase_nx = PH_DONE;
                end
            end
            default: begin
                w_phase_nx = PH_DONE;
            end
        endcase
    end

    // derivative join
    assign w_q_s       = $signed({2'b0, w_quo});
    assign w_deriv     = !r_use_div ? '0 : (r_neg ? -w_q_s : w_q_s);
    assign w_left_fin  = r_left_base + w_deriv;
    assign w_right_fin = r_right_base + w_deriv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_prior      <= '0;
            r_older      <= '0;
            r_run_before <= '0;
            r_run_now    <= '0;
            r_gate_done  <= 1'b0;
            r_slow       <= 1'b0;
            r_phase      <= PH_FOLLOW;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_state == ST_FIN && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_s_accept) begin
                        r_state <= ST_EVAL;
                    end
                end
                ST_EVAL: begin
                    r_prior      <= w_prior_nx;
                    r_older      <= w_older_nx;
                    r_run_before <= w_rb_nx;
                    r_run_now    <= w_rn_nx;
                    r_gate_done  <= w_gate_nx;
                    r_slow       <= w_slow_nx;
                    r_phase      <= w_phase_nx;
                    r_state      <= w_use_div_nx ? ST_DIV : ST_FIN;
                end
                ST_DIV: begin
                    if (w_div_done) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_accept) begin
            r_lv     <= i_s_axis_tdata[9:0];
            r_clv    <= i_s_axis_tdata[19:10];
            r_crv    <= i_s_axis_tdata[29:20];
            r_rv     <= i_s_axis_tdata[39:30];
            r_ld     <= i_s_axis_tdata[55:40];
            r_rd     <= i_s_axis_tdata[71:56];
            r_beacon <= i_s_axis_tdata[81:72];
            r_ms     <= i_s_axis_tdata[97:82];
        end
        if (r_state == ST_EVAL) begin
            r_left_base  <= w_left_nx;
            r_right_base <= w_right_nx;
            r_err        <= w_err_nx;
            r_neg        <= w_diff[ERR_W];
            r_use_div    <= w_use_div_nx;
        end
        if (r_state == ST_FIN && w_out_free) begin
            r_out_data <= {3'b0, (r_phase == PH_DONE), r_phase, r_err,
                           w_right_fin, w_left_fin};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    `LFPD_ASSERT_NEXT(a_accept_to_eval, w_s_accept, r_state == ST_EVAL, "accepted item did not enter evaluation")
    `LFPD_ASSERT_NOW(a_div_done_in_div, w_div_done, r_state == ST_DIV, "divider finished outside divide step")
    `LFPD_ASSERT_NOW(a_phase_legal, 1'b1, r_phase <= PH_DONE, "phase register holds an unused code")
    `LFPD_ASSERT_NOW(a_cross_matches_phase, r_out_valid, r_out_data[36] == (r_out_data[35:33] == PH_DONE), "cross flag disagrees with phase")

endmodule

FILE: tb/line_follow_pd_controller_core_tb.sv
// Self-checking stream testbench for the line follower PD controller core
module line_follow_pd_controller_core_tb
    import lfpd_pkg::*;
();

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
    localparam int LIMIT_CYCLES  = 200000;
    localparam int SETTLE_CYCLES = 24;
    localparam int MAX_REPORTS   = 40;
    localparam int IDLE_PCT      = 15;
    localparam int LEVEL_MAX     = 2**LEVEL_W - 1;
    localparam int DIST_MAX      = 2**DIST_W - 1;

    typedef struct packed {
        logic [DIST_W-1:0]  elapsed_ms;
        logic [LEVEL_W-1:0] beacon_level;
        logic [DIST_W-1:0]  right_wheel_distance;
        logic [DIST_W-1:0]  left_wheel_distance;
        logic [LEVEL_W-1:0] right_level;
        logic [LEVEL_W-1:0] centre_right_level;
        logic [LEVEL_W-1:0] centre_left_level;
        logic [LEVEL_W-1:0] left_level;
    } t_sample;

    typedef struct packed {
        logic                      cross_found;
        logic [PHASE_W-1:0]        phase_now;
        logic signed [ERR_W-1:0]   line_error;
        logic signed [DRIVE_W-1:0] right_drive;
        logic signed [DRIVE_W-1:0] left_drive;
    } t_motor_cmd;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    // left_level, centre_left_level, centre_right_level, right_level,
    // left_wheel_distance, right_wheel_distance, beacon_level, elapsed_ms
    logic [S_TDATA_W-1:0]  i_s_axis_tdata;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    // left_drive, right_drive, line_error, phase_now, cross_found
    logic [M_TDATA_W-1:0]  o_m_axis_tdata;
    logic                  i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    t_cfg                    cfg_q;
    logic signed [ERR_W-1:0] last_err;
    logic signed [ERR_W-1:0] prev_err;
    logic [RUN_W-1:0]        run_prev;
    logic [RUN_W-1:0]        run_cur;
    logic                    gate_seen;
    logic                    slow_latched;
    logic [PHASE_W-1:0]      phase_q;

    t_motor_cmd pending_cmds[$];
    int  fail_count   = 0;
    int  report_count = 0;
    int  cycle_count  = 0;
    bit  no_idle      = 1'b0;
    int  hold_request = 0;
    int  hold_left    = 0;

    line_follow_pd_controller_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic [LEVEL_W-1:0] eff_threshold();
        return slow_latched ? SLOW_THRESHOLD : cfg_q.sensor_threshold;
    endfunction

    function automatic int eff_speed();
        return slow_latched ? int'(SLOW_SPEED) : int'(cfg_q.base_speed);
    endfunction

    function automatic void advance_beacon(input logic [LEVEL_W-1:0] beacon);
        if (phase_q == PH_WAIT_RISE && beacon >= cfg_q.beacon_threshold) begin
            phase_q = PH_WAIT_FALL;
        end
        if (phase_q == PH_WAIT_FALL && beacon <= cfg_q.beacon_threshold) begin
            phase_q = PH_FOLLOW;
        end
    endfunction

    function automatic t_motor_cmd predict_motor_cmd(input t_sample s);
        t_motor_cmd         c;
        logic [DIST_W:0]    dist_sum;
        logic [DIST_W-1:0]  mean_dist;
        logic [LEVEL_W-1:0] thr;
        logic               on_l, on_cl, on_cr, on_r;
        int                 spd, pg, dg, err, num, den, deriv, con;
        int                 left_v, right_v, err_v;
        left_v  = 0;
        right_v = 0;
        err_v   = 0;
        case (phase_q) inside
            PH_FOLLOW: begin
                dist_sum  = s.left_wheel_distance + s.right_wheel_distance;
                mean_dist = dist_sum[DIST_W:1];
                if (mean_dist > cfg_q.slow_distance) begin
                    slow_latched = 1'b1;
                end
                if (!gate_seen && mean_dist > cfg_q.gate_distance) begin
                    gate_seen = 1'b1;
                    phase_q   = PH_WAIT_RISE;
                    advance_beacon(s.beacon_level);
                end else begin
                    thr   = eff_threshold();
                    spd   = eff_speed();
                    on_l  = s.left_level > thr;
                    on_cl = s.centre_left_level > thr;
                    on_cr = s.centre_right_level > thr;
                    on_r  = s.right_level > thr;
                    if (on_l && on_cl && on_cr && on_r) err = ERR_ALL_ON;
                    else if (on_cl && on_cr) err = ERR_CENTRE;
                    else if (on_cl) err = ERR_LEFT;
                    else if (on_cr) err = ERR_RIGHT;
                    else err = (last_err > 0) ? ERR_LOST_POS : ERR_LOST_NEG;
                    err_v = err;
                    if (err == ERR_ALL_ON && s.elapsed_ms > CROSS_MIN_MS) begin
                        phase_q = PH_TURN;
                        left_v  = -spd;
                        right_v = -spd;
                    end else begin
                        pg = slow_latched ? int'(SLOW_PROP) : int'(cfg_q.prop_gain);
                        dg = slow_latched ? int'(SLOW_DERIV) : int'(cfg_q.deriv_gain);
                        if (err != last_err) begin
                            prev_err = last_err;
                            run_prev = run_cur;
                            run_cur  = 1;
                        end
                        num   = dg * (err - prev_err);
                        den   = run_prev + run_cur;
                        deriv = (den != 0) ? num / den : 0;
                        con   = pg * err + deriv;
                        if (run_cur != '1) begin
                            run_cur = run_cur + 1'b1;
                        end
                        left_v   = con - spd;
                        right_v  = con + spd;
                        last_err = ERR_W'(err);
                    end
                end
            end
            PH_WAIT_RISE, PH_WAIT_FALL: begin
                advance_beacon(s.beacon_level);
            end
            PH_TURN: begin
                if (s.centre_left_level < eff_threshold()) begin
                    left_v  = -eff_speed();
                    right_v = -eff_speed();
                end else begin
                    phase_q = PH_DONE;
                end
            end
            default: begin
                phase_q = PH_DONE;
            end
        endcase
        c.left_drive  = left_v[DRIVE_W-1:0];
        c.right_drive = right_v[DRIVE_W-1:0];
        c.line_error  = err_v[ERR_W-1:0];
        c.phase_now   = phase_q;
        c.cross_found = (phase_q == PH_DONE);
        return c;
    endfunction

    function automatic logic [LEVEL_W-1:0] pick_level(input logic [LEVEL_W-1:0] thr);
        int t;
        t = thr;
        case ($urandom_range(9)) inside
            0: return '0;
            1: return '1;
            2: return thr;
            3: return thr + 1'b1;
            [4:6]: begin
                if (t == LEVEL_MAX) return LEVEL_W'($urandom);
                return LEVEL_W'($urandom_range(LEVEL_MAX, t + 1));
            end
            default: return LEVEL_W'($urandom_range(t, 0));
        endcase
    endfunction

    function automatic t_sample follow_sample(input int dist_cap);
        t_sample            s;
        logic [LEVEL_W-1:0] thr;
        thr = eff_threshold();
        s.left_level           = pick_level(thr);
        s.centre_left_level    = pick_level(thr);
        s.centre_right_level   = pick_level(thr);
        s.right_level          = pick_level(thr);
        s.left_wheel_distance  = DIST_W'($urandom_range(dist_cap, 0));
        s.right_wheel_distance = DIST_W'($urandom_range(dist_cap, 0));
        s.beacon_level         = LEVEL_W'($urandom);
        s.elapsed_ms           = DIST_W'($urandom);
        // hold off the crossbar turn until the last test
        if (s.left_level > thr && s.centre_left_level > thr && s.centre_right_level > thr
                && s.right_level > thr && s.elapsed_ms > CROSS_MIN_MS) begin
            s.elapsed_ms = DIST_W'($urandom_range(int'(CROSS_MIN_MS), 0));
        end
        return s;
    endfunction

    function automatic t_cfg random_cfg(input int dist_lo);
        t_cfg c;
        c.sensor_threshold = LEVEL_W'($urandom);
        c.prop_gain        = GAIN_W'($urandom);
        c.deriv_gain       = GAIN_W'($urandom);
        c.base_speed       = LEVEL_W'($urandom);
        c.gate_distance    = DIST_W'($urandom_range(DIST_MAX, dist_lo));
        c.beacon_threshold = LEVEL_W'($urandom);
        c.slow_distance    = DIST_W'($urandom_range(DIST_MAX, dist_lo));
        return c;
    endfunction

    task automatic report_mismatch(input string what, input t_motor_cmd got,
                                   input t_motor_cmd want);
        fail_count++;
        if (report_count < MAX_REPORTS) begin
            report_count++;
            $display("mismatch %s: got %h expected %h at cycle %0d",
                     what, got, want, cycle_count);
        end
    endtask

    task automatic send_sample(input t_sample s);
        if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= S_TDATA_W'(s);
        do @(posedge i_clk); while (!o_s_axis_tready);
        pending_cmds.push_back(predict_motor_cmd(s));
    endtask

    task automatic wait_all_results();
        i_s_axis_tvalid <= 1'b0;
        while (pending_cmds.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        unique case (idx)
            CFG_SENSOR_THR: cfg_q.sensor_threshold = val[LEVEL_W-1:0];
            CFG_PROP_GAIN:  cfg_q.prop_gain        = val[GAIN_W-1:0];
            CFG_DERIV_GAIN: cfg_q.deriv_gain       = val[GAIN_W-1:0];
            CFG_BASE_SPEED: cfg_q.base_speed       = val[LEVEL_W-1:0];
            CFG_GATE_DIST:  cfg_q.gate_distance    = val[DIST_W-1:0];
            CFG_BEACON_THR: cfg_q.beacon_threshold = val[LEVEL_W-1:0];
            CFG_SLOW_DIST:  cfg_q.slow_distance    = val[DIST_W-1:0];
            default: ;
        endcase
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_settings(input t_cfg c);
        wait_all_results();
        cfg_write(CFG_SENSOR_THR, CFG_DATA_W'({$urandom, c.sensor_threshold}));
        cfg_write(CFG_PROP_GAIN,  CFG_DATA_W'({$urandom, c.prop_gain}));
        cfg_write(CFG_DERIV_GAIN, CFG_DATA_W'({$urandom, c.deriv_gain}));
        cfg_write(CFG_BASE_SPEED, CFG_DATA_W'({$urandom, c.base_speed}));
        cfg_write(CFG_GATE_DIST,  c.gate_distance);
        cfg_write(CFG_BEACON_THR, CFG_DATA_W'({$urandom, c.beacon_threshold}));
        cfg_write(CFG_SLOW_DIST,  c.slow_distance);
        cfg_write(CFG_SPARE,      CFG_DATA_W'($urandom));
    endtask

    task automatic test_reset_defaults();
        t_sample s;
        s = '0;
        send_sample(s);
        s.centre_left_level = cfg_q.sensor_threshold + 1'b1;
        send_sample(s);
        s.centre_left_level  = cfg_q.sensor_threshold;
        s.centre_right_level = '1;
        send_sample(s);
        s.centre_right_level = '0;
        send_sample(s);
        s.left_level  = '1;
        s.right_level = '1;
        send_sample(s);
        s.centre_left_level  = '1;
        s.centre_right_level = '1;
        s.elapsed_ms         = CROSS_MIN_MS;
        send_sample(s);
        s.left_level = '0;
        send_sample(s);
        s.elapsed_ms = '1;
        send_sample(s);
        s.left_level = '1;
        s.elapsed_ms = CROSS_MIN_MS;
        send_sample(s);
        s.left_wheel_distance  = cfg_q.gate_distance;
        s.right_wheel_distance = cfg_q.gate_distance;
        send_sample(s);
        s = '0;
        s.beacon_level         = '1;
        s.right_wheel_distance = DIST_W'(2 * int'(cfg_q.gate_distance) + 1);
        send_sample(s);
    endtask

    task automatic test_gain_extremes();
        t_cfg    c;
        t_sample s;
        c = '{sensor_threshold: 10'd512, prop_gain: '1, deriv_gain: '1, base_speed: '1,
              gate_distance: '1, beacon_threshold: '1, slow_distance: '1};
        apply_settings(c);
        s = '0;
        s.left_wheel_distance  = '1;
        s.right_wheel_distance = '1;
        s.elapsed_ms           = CROSS_MIN_MS;
        send_sample(s);
        s.left_level         = '1;
        s.centre_left_level  = '1;
        s.centre_right_level = '1;
        s.right_level        = '1;
        send_sample(s);
        s.left_level         = '0;
        s.centre_left_level  = '0;
        s.centre_right_level = '0;
        s.right_level        = '0;
        send_sample(s);
        repeat (30) send_sample(follow_sample(DIST_MAX));
        c = '{sensor_threshold: '0, prop_gain: '0, deriv_gain: '0, base_speed: '0,
              gate_distance: '1, beacon_threshold: '0, slow_distance: '1};
        apply_settings(c);
        repeat (30) send_sample(follow_sample(DIST_MAX));
        c = '{sensor_threshold: '1, prop_gain: 8'd1, deriv_gain: 8'd1, base_speed: 10'd1,
              gate_distance: '1, beacon_threshold: 10'd512, slow_distance: '1};
        apply_settings(c);
        repeat (20) send_sample(follow_sample(DIST_MAX));
    endtask

    task automatic test_random_follow();
        t_cfg c;
        int   cap;
        for (int blk = 0; blk < 13; blk++) begin
            c = random_cfg(DIST_MAX / 2 + 1);
            apply_settings(c);
            cap = (c.gate_distance < c.slow_distance) ? c.gate_distance : c.slow_distance;
            no_idle = (blk == 3);
            if (blk == 6) begin
                hold_request = 400;
            end
            repeat (100) send_sample(follow_sample(cap));
        end
        no_idle = 1'b0;
    endtask

    task automatic test_gate_and_beacon();
        t_cfg    c;
        t_sample s;
        int      bthr;
        c = random_cfg(0);
        c.gate_distance    = DIST_W'($urandom_range(30000, 100));
        c.slow_distance    = '1;
        c.beacon_threshold = LEVEL_W'($urandom_range(1000, 20));
        apply_settings(c);
        bthr = c.beacon_threshold;
        repeat (10) send_sample(follow_sample(c.gate_distance));
        s = follow_sample(c.gate_distance);
        s.left_wheel_distance  = '1;
        s.right_wheel_distance = c.gate_distance + 1'b1;
        s.beacon_level         = LEVEL_W'($urandom_range(bthr - 1, 0));
        send_sample(s);
        repeat ($urandom_range(40, 10)) begin
            s = follow_sample(DIST_MAX);
            s.beacon_level = LEVEL_W'($urandom_range(bthr - 1, 0));
            send_sample(s);
        end
        repeat ($urandom_range(20, 5)) begin
            s = follow_sample(DIST_MAX);
            s.beacon_level = LEVEL_W'($urandom_range(LEVEL_MAX, bthr + 1));
            send_sample(s);
        end
        s = follow_sample(DIST_MAX);
        s.beacon_level = LEVEL_W'(bthr);
        send_sample(s);
        repeat (40) send_sample(follow_sample(DIST_MAX));
    endtask

    task automatic test_slow_mode();
        t_cfg    c;
        t_sample s;
        c = random_cfg(0);
        c.slow_distance = DIST_W'($urandom_range(60000, 2000));
        apply_settings(c);
        repeat (20) send_sample(follow_sample(c.slow_distance));
        s = follow_sample(c.slow_distance);
        s.left_wheel_distance  = '1;
        s.right_wheel_distance = c.slow_distance + 1'b1;
        s.elapsed_ms           = DIST_W'($urandom_range(int'(CROSS_MIN_MS), 0));
        send_sample(s);
        repeat (80) send_sample(follow_sample(DIST_MAX));
        apply_settings(random_cfg(0));
        repeat (60) send_sample(follow_sample(DIST_MAX));
    endtask

    task automatic test_crossbar_turn();
        t_sample s;
        s = follow_sample(DIST_MAX);
        s.left_level         = '1;
        s.centre_left_level  = '1;
        s.centre_right_level = '1;
        s.right_level        = '1;
        s.elapsed_ms         = CROSS_MIN_MS + 1'b1;
        send_sample(s);
        repeat ($urandom_range(12, 4)) begin
            s = follow_sample(DIST_MAX);
            s.centre_left_level = LEVEL_W'($urandom_range(int'(eff_threshold()) - 1, 0));
            send_sample(s);
        end
        s = follow_sample(DIST_MAX);
        s.centre_left_level = eff_threshold();
        send_sample(s);
        repeat (10) send_sample(follow_sample(DIST_MAX));
    endtask

    always @(posedge i_clk) begin : result_check
        t_motor_cmd got;
        t_motor_cmd want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = o_m_axis_tdata[$bits(t_motor_cmd)-1:0];
            if (pending_cmds.size() == 0) begin
                report_mismatch("item with nothing expected", got, got);
            end else begin
                want = pending_cmds.pop_front();
                if (got.left_drive !== want.left_drive)
                    report_mismatch("left_drive", got, want);
                if (got.right_drive !== want.right_drive)
                    report_mismatch("right_drive", got, want);
                if (got.line_error !== want.line_error)
                    report_mismatch("line_error", got, want);
                if (got.phase_now !== want.phase_now)
                    report_mismatch("phase_now", got, want);
                if (got.cross_found !== want.cross_found)
                    report_mismatch("cross_found", got, want);
            end
        end
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("** line_follow_pd_controller_core: FAILED **");
            $finish;
        end
    end

    initial begin
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_cfg_wr_en     <= 1'b0;
        i_cfg_index     <= '0;
        i_cfg_wdata     <= '0;
        cfg_q = '{sensor_threshold: RST_SENSOR_THR, prop_gain: RST_PROP_GAIN,
                  deriv_gain: RST_DERIV_GAIN, base_speed: RST_BASE_SPEED,
                  gate_distance: RST_GATE_DIST, beacon_threshold: RST_BEACON_THR,
                  slow_distance: RST_SLOW_DIST};
        last_err     = '0;
        prev_err     = '0;
        run_prev     = '0;
        run_cur      = '0;
        gate_seen    = 1'b0;
        slow_latched = 1'b0;
        phase_q      = PH_FOLLOW;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_gain_extremes();
        test_random_follow();
        test_gate_and_beacon();
        test_slow_mode();
        test_crossbar_turn();
        wait_all_results();
        if (fail_count == 0) begin
            $display("** line_follow_pd_controller_core: PASSED **");
        end else begin
            $display("** line_follow_pd_controller_core: FAILED **");
        end
        $finish;
    end

endmodule
